// ===== rtl/core/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; the engine core and the top level use it.
package i2cmbe_pkg;

    // Width of the half-period wait counter
    localparam int WAIT_BITS = 16;

    // Command codes carried in the mode field
    localparam logic [2:0] CMD_IDLE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_RESTART   = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;
    localparam logic [2:0] CMD_BUS_RESET = 3'd6;

    // Completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_NACK     = 2'd3;

    // Reset value of the half-period register
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

    // One input word: command plus sampled bus lines
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } in_word_t;

    // One result word: line drives and command status
    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } out_word_t;

endpackage

// ===== rtl/core/i2cmbe_engine.sv =====
// Bus sequencing core: command state, per-tick next-state logic and result word.
// Depends on i2cmbe_pkg for command/status codes and the word types.
module i2cmbe_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  i2cmbe_pkg::in_word_t        in_word,
    input  logic [15:0]                 half_period,
    output i2cmbe_pkg::out_word_t       res_word
);

    // Sequencing phases within one bus element
    typedef enum logic [3:0] {
        PH_SETUP  = 4'd0,
        PH_DRIVE  = 4'd1,
        PH_VERIFY = 4'd2,
        PH_SDA    = 4'd3,
        PH_RISE   = 4'd4,
        PH_SAMPLE = 4'd5,
        PH_HOLD   = 4'd6,
        PH_FALL   = 4'd7,
        PH_ACK    = 4'd8
    } phase_t;

    // Element kinds of a command sequence
    typedef enum logic [2:0] {
        K_END = 3'd0,
        K_SET = 3'd1,
        K_TX  = 3'd2,
        K_RXD = 3'd3,
        K_RXA = 3'd4,
        K_RXX = 3'd5
    } kind_t;

    localparam logic LINE_SCL = 1'b0;
    localparam logic LINE_SDA = 1'b1;

    logic [2:0]                          cmd_reg,    cmd_next;
    phase_t                              phase_reg,  phase_next;
    logic [3:0]                          bit_reg,    bit_next;
    logic [i2cmbe_pkg::WAIT_BITS-1:0]    wait_reg,   wait_next;
    logic [7:0]                          shift_reg,  shift_next;
    logic [1:0]                          line_reg,   line_next;
    logic [1:0]                          status_reg, status_next;
    logic [7:0]                          held_reg,   held_next;
    logic                                ack_reg,    ack_next;

    logic [i2cmbe_pkg::WAIT_BITS-1:0]    wait_load;
    logic                                done;

    // Decoded current element
    kind_t      e_kind;
    logic       e_line;
    logic       e_low;
    logic       e_level;
    logic [3:0] j_idx;
    logic [3:0] stop_idx;

    assign wait_load = i2cmbe_pkg::WAIT_BITS'(half_period);

    // Element decode: what the command does at step bit_reg
    always_comb begin
        e_kind   = K_END;
        e_line   = LINE_SCL;
        e_low    = 1'b0;
        e_level  = 1'b0;
        j_idx    = (cmd_reg == i2cmbe_pkg::CMD_RESTART) ? (bit_reg - 4'd2) : bit_reg;
        stop_idx = (cmd_reg == i2cmbe_pkg::CMD_BUS_RESET) ? (bit_reg - 4'd9) : bit_reg;
        case (cmd_reg)
            i2cmbe_pkg::CMD_START, i2cmbe_pkg::CMD_RESTART: begin
                if (cmd_reg == i2cmbe_pkg::CMD_RESTART && bit_reg == 4'd0) begin
                    e_kind = K_SET; e_line = LINE_SCL; e_low = 1'b0;
                end else if (cmd_reg == i2cmbe_pkg::CMD_RESTART && bit_reg == 4'd1) begin
                    e_kind = K_SET; e_line = LINE_SDA; e_low = 1'b0;
                end else if (j_idx == 4'd0) begin
                    e_kind = K_SET; e_line = LINE_SDA; e_low = 1'b1;
                end else if (j_idx == 4'd1) begin
                    e_kind = K_SET; e_line = LINE_SCL; e_low = 1'b1;
                end else if (j_idx <= 4'd9) begin
                    e_kind  = K_TX;
                    e_level = shift_reg[3'(4'd9 - j_idx)];
                end else if (j_idx == 4'd10) begin
                    e_kind = K_RXA;
                end
            end
            i2cmbe_pkg::CMD_WRITE: begin
                if (bit_reg < 4'd8) begin
                    e_kind  = K_TX;
                    e_level = shift_reg[3'(4'd7 - bit_reg)];
                end else if (bit_reg == 4'd8) begin
                    e_kind = K_RXA;
                end
            end
            i2cmbe_pkg::CMD_READ: begin
                if (bit_reg < 4'd8) begin
                    e_kind = K_RXD;
                end else if (bit_reg == 4'd8) begin
                    e_kind  = K_TX;
                    e_level = ack_reg;
                end
            end
            i2cmbe_pkg::CMD_STOP, i2cmbe_pkg::CMD_BUS_RESET: begin
                if (cmd_reg == i2cmbe_pkg::CMD_BUS_RESET && bit_reg < 4'd9) begin
                    e_kind = K_RXX;
                end else begin
                    case (stop_idx)
                        4'd0: begin e_kind = K_SET; e_line = LINE_SCL; e_low = 1'b1; end
                        4'd1: begin e_kind = K_SET; e_line = LINE_SDA; e_low = 1'b1; end
                        4'd2: begin e_kind = K_SET; e_line = LINE_SCL; e_low = 1'b0; end
                        4'd3: begin e_kind = K_SET; e_line = LINE_SDA; e_low = 1'b0; end
                        default: e_kind = K_END;
                    endcase
                end
            end
            default: e_kind = K_END;
        endcase
    end

    // Per-tick next state
    always_comb begin
        logic       fin;
        logic [1:0] fin_code;
        logic       line_in;

        cmd_next    = cmd_reg;
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        wait_next   = wait_reg;
        shift_next  = shift_reg;
        line_next   = line_reg;
        status_next = status_reg;
        held_next   = held_reg;
        ack_next    = ack_reg;
        done        = 1'b0;
        fin         = 1'b0;
        fin_code    = i2cmbe_pkg::ST_OK;
        line_in     = 1'b0;

        if (cmd_reg == i2cmbe_pkg::CMD_IDLE) begin
            // Command launch; mode seven is a plain tick
            if (in_word.mode >= i2cmbe_pkg::CMD_START &&
                in_word.mode <= i2cmbe_pkg::CMD_BUS_RESET) begin
                if (in_word.mode == i2cmbe_pkg::CMD_START &&
                    !(in_word.scl_in && in_word.sda_in)) begin
                    status_next = i2cmbe_pkg::ST_BUS_BUSY;
                    done        = 1'b1;
                end else begin
                    cmd_next    = in_word.mode;
                    status_next = i2cmbe_pkg::ST_OK;
                    phase_next  = PH_SETUP;
                    bit_next    = 4'd0;
                    wait_next   = '0;
                    shift_next  = (in_word.mode == i2cmbe_pkg::CMD_READ) ? 8'd0
                                                                          : in_word.data_byte;
                    ack_next    = !in_word.send_ack;
                end
            end
        end else if (wait_reg != '0) begin
            wait_next = wait_reg - 1'b1;
        end else if (e_kind == K_END) begin
            fin = 1'b1;
        end else if (e_kind == K_SET) begin
            // Single line change with readback
            case (phase_reg)
                PH_SETUP: begin
                    wait_next  = wait_load;
                    phase_next = PH_DRIVE;
                end
                PH_DRIVE: begin
                    line_next[e_line] = e_low;
                    wait_next         = wait_load;
                    phase_next        = PH_VERIFY;
                end
                default: begin
                    line_in = (e_line == LINE_SCL) ? in_word.scl_in : in_word.sda_in;
                    if (line_in != !e_low) begin
                        fin      = 1'b1;
                        fin_code = i2cmbe_pkg::ST_MISMATCH;
                    end else begin
                        bit_next   = bit_reg + 4'd1;
                        phase_next = PH_SETUP;
                    end
                end
            endcase
        end else begin
            // One SCL clock: transmit, receive or dummy bit
            case (phase_reg)
                PH_SETUP: begin
                    wait_next  = wait_load;
                    phase_next = PH_DRIVE;
                end
                PH_DRIVE: begin
                    line_next[LINE_SCL] = 1'b1;
                    wait_next           = wait_load;
                    phase_next          = PH_VERIFY;
                end
                PH_VERIFY: begin
                    if (in_word.scl_in) begin
                        fin      = 1'b1;
                        fin_code = i2cmbe_pkg::ST_MISMATCH;
                    end else begin
                        phase_next = PH_SDA;
                    end
                end
                PH_SDA: begin
                    line_next[LINE_SDA] = (e_kind == K_TX) ? !e_level : 1'b0;
                    wait_next           = wait_load;
                    phase_next          = PH_RISE;
                end
                PH_RISE: begin
                    line_next[LINE_SCL] = 1'b0;
                    wait_next           = wait_load;
                    phase_next          = PH_SAMPLE;
                end
                PH_SAMPLE: begin
                    // Hold here while the slave stretches SCL
                    if (in_word.scl_in) begin
                        if (e_kind == K_TX && in_word.sda_in != e_level) begin
                            fin      = 1'b1;
                            fin_code = i2cmbe_pkg::ST_MISMATCH;
                        end else begin
                            if (e_kind != K_TX) begin
                                shift_next = {shift_reg[6:0], in_word.sda_in};
                            end
                            phase_next = PH_HOLD;
                        end
                    end
                end
                PH_HOLD: begin
                    wait_next  = wait_load;
                    phase_next = PH_FALL;
                end
                PH_FALL: begin
                    line_next[LINE_SCL] = 1'b1;
                    wait_next           = wait_load;
                    phase_next          = PH_ACK;
                end
                default: begin
                    if (in_word.scl_in) begin
                        fin      = 1'b1;
                        fin_code = i2cmbe_pkg::ST_MISMATCH;
                    end else if (e_kind == K_RXA && shift_reg[0]) begin
                        fin      = 1'b1;
                        fin_code = i2cmbe_pkg::ST_NACK;
                    end else begin
                        bit_next   = bit_reg + 4'd1;
                        phase_next = PH_SETUP;
                    end
                end
            endcase
        end

        // Command completion or abort
        if (fin) begin
            if (fin_code == i2cmbe_pkg::ST_OK && cmd_reg == i2cmbe_pkg::CMD_READ) begin
                held_next = shift_reg;
            end
            status_next = fin_code;
            cmd_next    = i2cmbe_pkg::CMD_IDLE;
            phase_next  = PH_SETUP;
            bit_next    = 4'd0;
            wait_next   = '0;
            done        = 1'b1;
        end
    end

    // Result word reflects the state after this tick
    always_comb begin
        res_word.scl_drive_low = line_next[LINE_SCL];
        res_word.sda_drive_low = line_next[LINE_SDA];
        res_word.busy_res      = (cmd_next != i2cmbe_pkg::CMD_IDLE);
        res_word.done_res      = done;
        res_word.status        = status_next;
        res_word.read_data     = held_next;
    end

    // State registers, advanced once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg    <= i2cmbe_pkg::CMD_IDLE;
            phase_reg  <= PH_SETUP;
            bit_reg    <= 4'd0;
            wait_reg   <= '0;
            shift_reg  <= 8'd0;
            line_reg   <= 2'b00;
            status_reg <= i2cmbe_pkg::ST_OK;
            held_reg   <= 8'd0;
            ack_reg    <= 1'b0;
        end else if (step) begin
            cmd_reg    <= cmd_next;
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            wait_reg   <= wait_next;
            shift_reg  <= shift_next;
            line_reg   <= line_next;
            status_reg <= status_next;
            held_reg   <= held_next;
            ack_reg    <= ack_next;
        end
    end

`ifndef SYNTH
    // Idle engine carries no leftover sequencing state
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == i2cmbe_pkg::CMD_IDLE) |->
            (phase_reg == PH_SETUP && bit_reg == 4'd0 && wait_reg == '0))
        else $error("idle engine with nonzero phase, step or wait count");

    // A pending wait only counts down on a step
    a_wait_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && cmd_reg != i2cmbe_pkg::CMD_IDLE && wait_reg != '0) |=>
            (wait_reg == i2cmbe_pkg::WAIT_BITS'($past(wait_reg) - 1'b1) &&
             line_reg == $past(line_reg)))
        else $error("wait tick changed more than the counter");

    // Completion and busy are exclusive in a result word
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_word.done_res |-> !res_word.busy_res)
        else $error("result word both done and busy");

    // State holds when no word is taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(cmd_reg) && $stable(phase_reg) && $stable(wait_reg) &&
                   $stable(line_reg)))
        else $error("engine state moved without an accepted word");
`endif

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// I2C master byte engine: one result word per input word; input stalls while a result
// is held and not taken. A result word is registered as its input word is accepted.
// Throughput: 1 word per cycle; the output register refills while the old word is taken.
// Reset (aresetn low, synchronous): engine idle, lines released, half period 250.
// Depends on i2cmbe_pkg and i2cmbe_engine.
module i2c_master_byte_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  i2cmbe_pkg::in_word_t        s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output i2cmbe_pkg::out_word_t       m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [15:0]                 cfg_wdata
);

    logic                   s_accept;
    logic                   m_valid_reg;
    i2cmbe_pkg::out_word_t  m_data_reg;
    i2cmbe_pkg::out_word_t  res_word;
    logic [15:0]            half_period_reg;

    // Input taken whenever the output register is free or draining
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    i2cmbe_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_accept),
        .in_word     (s_data),
        .half_period (half_period_reg),
        .res_word    (res_word)
    );

    // Half-period configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= i2cmbe_pkg::HALF_PERIOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            half_period_reg <= cfg_wdata;
        end
    end

    // Result output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= res_word;
        end
    end

endmodule
